// File: rtl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants of the PDU transmission-mode scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

    // default number of table rows and reset value of the PDU count register
    localparam int unsigned PDU_SLOTS_DEF = 64;
    localparam logic [6:0]  PDU_COUNT_RST = 7'd64;

    // operation codes of an input transfer
    typedef enum logic [1:0] {
        OP_EVAL = 2'd0,
        OP_TRIG = 2'd1,
        OP_CONF = 2'd2,
        OP_RSVD = 2'd3
    } op_t;

    // transmission modes
    typedef enum logic [1:0] {
        MODE_NONE     = 2'd0,
        MODE_PERIODIC = 2'd1,
        MODE_DIRECT   = 2'd2,
        MODE_MIXED    = 2'd3
    } mode_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_PER,
        ST_CNT,
        ST_REP,
        ST_WRITE
    } state_t;

    // one table row
    typedef struct packed {
        logic [15:0] period_timer;
        logic        trigger_flag;
        logic [7:0]  repeats_left;
        logic [15:0] repeat_timer;
    } tbl_row_t;

    // table write request
    typedef struct packed {
        logic     en;
        tbl_row_t row;
    } tbl_wr_t;

    // shared count-down unit operands and result
    typedef struct packed {
        logic [15:0] operand;
        logic [15:0] reload;
    } step_in_t;

    typedef struct packed {
        logic        zero;
        logic [15:0] result;
    } step_out_t;

endpackage

// File: rtl/pts_if.sv
// ----------------------------------------------------------------------------
// pts_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------

// request channel
interface pts_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [5:0]  pdu_index;
    logic        pdu_active;
    logic [1:0]  tx_mode;
    logic [15:0] period_ticks;
    logic [7:0]  repeat_total;
    logic [15:0] repeat_period_ticks;
    logic        confirm_ok;

    modport source (
        output valid, operation, pdu_index, pdu_active, tx_mode,
               period_ticks, repeat_total, repeat_period_ticks, confirm_ok,
        input  ready
    );

    modport sink (
        input  valid, operation, pdu_index, pdu_active, tx_mode,
               period_ticks, repeat_total, repeat_period_ticks, confirm_ok,
        output ready
    );
endinterface

// result channel
interface pts_out_if;
    logic valid;
    logic ready;
    logic send_now;
    logic index_valid;

    modport source (
        output valid, send_now, index_valid,
        input  ready
    );

    modport sink (
        input  valid, send_now, index_valid,
        output ready
    );
endinterface

// File: rtl/pts_step_unit.sv
// ----------------------------------------------------------------------------
// pts_step_unit
// Shared count-down unit: zero test, then reload or decrement.
// ----------------------------------------------------------------------------
module pts_step_unit
    import pts_pkg::*;
(
    input  step_in_t  step_in,
    output step_out_t step_out
);

    // zero detect and reload-or-decrement
    always_comb
    begin
        step_out.zero   = (step_in.operand == 16'd0);
        step_out.result = step_out.zero ? step_in.reload
                                        : (step_in.operand - 16'd1);
    end

endmodule

// File: rtl/pts_table.sv
// ----------------------------------------------------------------------------
// pts_table
// Per-PDU state memory with row valid bits; an unwritten row reads as zero.
// ----------------------------------------------------------------------------
module pts_table
    import pts_pkg::*;
#(
    parameter int unsigned SLOTS = PDU_SLOTS_DEF
)
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     rd_en,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    output tbl_row_t                                 rd_row,
    input  tbl_wr_t                                  wr,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr
);

    tbl_row_t         mem [SLOTS];
    tbl_row_t         rd_data_reg;
    logic             rd_vld_reg;
    logic [SLOTS-1:0] row_vld_reg;

    // memory array, registered read
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // row valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                row_vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= row_vld_reg[rd_addr];
            end
        end
    end

    // a row never written reads as zero
    assign rd_row = rd_vld_reg ? rd_data_reg : '0;

endmodule

// File: rtl/pdu_tx_mode_scheduler_core.sv
// ----------------------------------------------------------------------------
// pdu_tx_mode_scheduler_core
// Per-PDU transmission-mode scheduler with a sequenced count-down unit.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (valid/ready): evaluate, set trigger or
// transmit confirmation for one PDU. Each request gives exactly one transfer
// on the result channel carrying send_now and index_valid. pdu_count is set
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block
// is idle, as the block itself does not enforce this. A request is taken only
// in the idle state. It then reads its table row (read and load states), runs
// up to three passes through the one shared count-down unit (period timer,
// repetition count, repetition timer) and writes the row back; the next
// request is taken only after the write-back. The result register is set in
// the cycle after the write-back and a new request is taken while it still
// waits. If the receiver stalls, the sequencer holds in the write-back state
// until the result register is free. Reset clears the row valid bits, so every
// row reads as zero at once, and loads pdu_count with 64; no clearing pass.
// ----------------------------------------------------------------------------
module pdu_tx_mode_scheduler_core
    import pts_pkg::*;
#(
    parameter int unsigned PDU_SLOTS = PDU_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    pts_in_if.sink      item,
    pts_out_if.source   result
);

    localparam int unsigned SLOT_W  = (PDU_SLOTS > 1) ? $clog2(PDU_SLOTS) : 1;
    localparam logic [8:0]  SLOTS_9 = 9'(PDU_SLOTS);

    state_t      state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;

    // captured request
    op_t         op_reg, op_next;
    logic [5:0]  idx_reg, idx_next;
    logic        active_reg, active_next;
    mode_t       mode_reg, mode_next;
    logic [15:0] period_reg, period_next;
    logic [7:0]  reps_reg, reps_next;
    logic [15:0] rep_period_reg, rep_period_next;
    logic        ok_reg, ok_next;

    // working state
    logic        valid_reg, valid_next;
    tbl_row_t    row_reg, row_next;
    logic        send_reg, send_next;
    logic        reps_zero_reg, reps_zero_next;
    logic [7:0]  reps_dec_reg, reps_dec_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    logic        out_send_reg, out_send_next;
    logic        out_idx_reg, out_idx_next;

    logic              accept;
    logic              wr_go;
    logic [8:0]        idx_ext;
    logic [SLOT_W-1:0] addr;
    logic              rd_en;
    tbl_row_t          rd_row;
    tbl_wr_t           tbl_wr;
    step_in_t          step_in;
    step_out_t         step_out;

    assign accept  = item.valid && item.ready;
    assign wr_go   = !out_valid_reg || result.ready;
    assign idx_ext = {3'b000, idx_reg};
    assign addr    = idx_ext[SLOT_W-1:0];

    // per-PDU state table
    pts_table #(
        .SLOTS (PDU_SLOTS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (addr),
        .rd_row  (rd_row),
        .wr      (tbl_wr),
        .wr_addr (addr)
    );

    // shared count-down unit
    pts_step_unit u_step (
        .step_in  (step_in),
        .step_out (step_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (valid_reg && (op_reg == OP_EVAL) && active_reg &&
                    ((mode_reg == MODE_PERIODIC) ||
                     ((mode_reg == MODE_MIXED) && !rd_row.trigger_flag)))
                begin
                    state_next = ST_PER;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_PER:
            begin
                if ((mode_reg == MODE_MIXED) && !step_out.zero)
                begin
                    state_next = ST_CNT;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_CNT:
            begin
                state_next = step_out.zero ? ST_WRITE : ST_REP;
            end
            ST_REP:
            begin
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (wr_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath
    always_comb
    begin
        item.ready      = (state_reg == ST_IDLE);
        rd_en           = (state_reg == ST_READ);
        tbl_wr.en       = 1'b0;
        tbl_wr.row      = row_reg;
        step_in.operand = '0;
        step_in.reload  = '0;

        cnt_next        = cfg_wr_en ? cfg_wr_data : cnt_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        mode_next       = mode_reg;
        period_next     = period_reg;
        reps_next       = reps_reg;
        rep_period_next = rep_period_reg;
        ok_next         = ok_reg;
        valid_next      = valid_reg;
        row_next        = row_reg;
        send_next       = send_reg;
        reps_zero_next  = reps_zero_reg;
        reps_dec_next   = reps_dec_reg;
        out_valid_next  = out_valid_reg;
        out_send_next   = out_send_reg;
        out_idx_next    = out_idx_reg;

        // result taken by the receiver
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = op_t'(item.operation);
                    idx_next        = item.pdu_index;
                    active_next     = item.pdu_active;
                    mode_next       = mode_t'(item.tx_mode);
                    period_next     = item.period_ticks;
                    reps_next       = item.repeat_total;
                    rep_period_next = item.repeat_period_ticks;
                    ok_next         = item.confirm_ok;
                end
            end
            ST_READ:
            begin
                valid_next = ({1'b0, idx_reg} < cnt_reg) && (idx_ext < SLOTS_9);
            end
            ST_LOAD:
            begin
                row_next  = rd_row;
                send_next = 1'b0;
                if (valid_reg)
                begin
                    case (op_reg)
                        OP_EVAL:
                        begin
                            if (active_reg && (mode_reg == MODE_DIRECT))
                            begin
                                send_next             = rd_row.trigger_flag;
                                row_next.trigger_flag = 1'b0;
                            end
                            else if (active_reg && (mode_reg == MODE_MIXED) &&
                                     rd_row.trigger_flag)
                            begin
                                // trigger starts a burst of repetitions
                                send_next             = 1'b1;
                                row_next.trigger_flag = 1'b0;
                                row_next.repeats_left = reps_reg;
                                row_next.repeat_timer = rep_period_reg;
                            end
                        end
                        OP_TRIG:
                        begin
                            row_next.trigger_flag = 1'b1;
                        end
                        OP_CONF:
                        begin
                            if (ok_reg)
                            begin
                                row_next.repeats_left = 8'd0;
                            end
                        end
                        default:
                        begin
                            row_next = rd_row;
                        end
                    endcase
                end
            end
            ST_PER:
            begin
                // period timer: reload at zero, else count down
                step_in.operand       = row_reg.period_timer;
                step_in.reload        = period_reg;
                row_next.period_timer = step_out.result;
                send_next             = step_out.zero;
            end
            ST_CNT:
            begin
                // repetitions left: test for zero and prepare the decrement
                step_in.operand = {8'd0, row_reg.repeats_left};
                reps_zero_next  = step_out.zero;
                reps_dec_next   = step_out.result[7:0];
            end
            ST_REP:
            begin
                // repetition timer: a zero timer sends one repetition
                step_in.operand       = row_reg.repeat_timer;
                step_in.reload        = rep_period_reg;
                row_next.repeat_timer = step_out.result;
                if (step_out.zero)
                begin
                    send_next             = 1'b1;
                    row_next.repeats_left = reps_dec_reg;
                end
            end
            ST_WRITE:
            begin
                if (wr_go)
                begin
                    tbl_wr.en      = valid_reg;
                    out_valid_next = 1'b1;
                    out_send_next  = send_reg;
                    out_idx_next   = valid_reg;
                end
            end
            default:
            begin
                tbl_wr.en = 1'b0;
            end
        endcase

        result.valid       = out_valid_reg;
        result.send_now    = out_send_reg;
        result.index_valid = out_idx_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= PDU_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        idx_reg        <= idx_next;
        active_reg     <= active_next;
        mode_reg       <= mode_next;
        period_reg     <= period_next;
        reps_reg       <= reps_next;
        rep_period_reg <= rep_period_next;
        ok_reg         <= ok_next;
        valid_reg      <= valid_next;
        row_reg        <= row_next;
        send_reg       <= send_next;
        reps_zero_reg  <= reps_zero_next;
        reps_dec_reg   <= reps_dec_next;
        out_send_reg   <= out_send_next;
        out_idx_reg    <= out_idx_next;
    end

    // a taken request starts a table read next cycle
    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_READ))
        else $error("request transfer not followed by table read");

    // a finished write-back always presents a result
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WRITE) && wr_go) |=> (result.valid && item.ready))
        else $error("write-back did not present a result");

    // a send is never reported for a rejected index
    a_send_valid_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (!result.send_now || result.index_valid))
        else $error("send reported for rejected index");

    // the repetition timer runs only while repetitions remain
    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REP) |-> ($past(state_reg) == ST_CNT) && !reps_zero_reg)
        else $error("repetition step without repetitions left");

endmodule

// File: bench/pts_sched_checker.sv
// ----------------------------------------------------------------------------
// pts_sched_checker
// Watches the request and result channels of the scheduler, keeps its own
// copy of the PDU table and the PDU count, predicts one verdict per request
// transfer and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module pts_sched_checker
    import pts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    pts_in_if           item,
    pts_out_if          result,
    output int unsigned fail_count,
    output int unsigned requests_taken,
    output int unsigned results_taken
);

    localparam int unsigned SLOTS = PDU_SLOTS_DEF;

    typedef struct packed {
        logic send_now;
        logic index_valid;
    } verdict_t;

    // shadow table and register
    logic [15:0] period_tmr [SLOTS];
    logic        trig_flag  [SLOTS];
    logic [7:0]  reps_left  [SLOTS];
    logic [15:0] rep_tmr    [SLOTS];
    logic [6:0]  pdu_limit;

    // verdicts still owed by the block, oldest first
    verdict_t    pending_verdicts [$];
    verdict_t    want;
    int unsigned errs;

    // table update and verdict for one request
    function automatic verdict_t apply_request(
        input op_t         op,
        input logic [5:0]  idx,
        input logic        active,
        input mode_t       mode,
        input logic [15:0] period,
        input logic [7:0]  reps,
        input logic [15:0] rep_period,
        input logic        ok
    );
        verdict_t v;
        v.send_now    = 1'b0;
        v.index_valid = (int'(idx) < int'(pdu_limit)) && (int'(idx) < int'(SLOTS));
        if (v.index_valid)
        begin
            case (op)
                OP_EVAL:
                begin
                    if (active)
                    begin
                        case (mode)
                            MODE_PERIODIC:
                            begin
                                if (period_tmr[idx] == 16'd0)
                                begin
                                    v.send_now      = 1'b1;
                                    period_tmr[idx] = period;
                                end
                                else
                                    period_tmr[idx] = period_tmr[idx] - 16'd1;
                            end
                            MODE_DIRECT:
                            begin
                                v.send_now     = trig_flag[idx];
                                trig_flag[idx] = 1'b0;
                            end
                            MODE_MIXED:
                            begin
                                // a pending trigger starts a fresh burst of repetitions
                                if (trig_flag[idx])
                                begin
                                    v.send_now     = 1'b1;
                                    trig_flag[idx] = 1'b0;
                                    reps_left[idx] = reps;
                                    rep_tmr[idx]   = rep_period;
                                end
                                else if (period_tmr[idx] == 16'd0)
                                begin
                                    v.send_now      = 1'b1;
                                    period_tmr[idx] = period;
                                end
                                else
                                    period_tmr[idx] = period_tmr[idx] - 16'd1;
                                // repetition timer only runs on a tick with no send
                                if (!v.send_now && reps_left[idx] != 8'd0)
                                begin
                                    if (rep_tmr[idx] == 16'd0)
                                    begin
                                        v.send_now     = 1'b1;
                                        reps_left[idx] = reps_left[idx] - 8'd1;
                                        rep_tmr[idx]   = rep_period;
                                    end
                                    else
                                        rep_tmr[idx] = rep_tmr[idx] - 16'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                OP_TRIG: trig_flag[idx] = 1'b1;
                OP_CONF:
                begin
                    if (ok)
                        reps_left[idx] = 8'd0;
                end
                default: ;
            endcase
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                period_tmr[i] = '0;
                trig_flag[i]  = 1'b0;
                reps_left[i]  = '0;
                rep_tmr[i]    = '0;
            end
            pdu_limit = PDU_COUNT_RST;
            pending_verdicts.delete();
            fail_count     <= 0;
            requests_taken <= 0;
            results_taken  <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_wr_en)
                pdu_limit = cfg_wr_data;

            // result transfer against the oldest prediction
            if (result.valid && result.ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected result: send_now=%0b index_valid=%0b",
                           result.send_now, result.index_valid);
                    errs++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (result.send_now !== want.send_now)
                    begin
                        $error("send_now: expected %0b, actual %0b",
                               want.send_now, result.send_now);
                        errs++;
                    end
                    if (result.index_valid !== want.index_valid)
                    begin
                        $error("index_valid: expected %0b, actual %0b",
                               want.index_valid, result.index_valid);
                        errs++;
                    end
                end
                results_taken <= results_taken + 1;
            end

            // request transfer: predict after the pop so an early result cannot match it
            if (item.valid && item.ready)
            begin
                pending_verdicts.push_back(apply_request(
                    op_t'(item.operation), item.pdu_index, item.pdu_active,
                    mode_t'(item.tx_mode), item.period_ticks, item.repeat_total,
                    item.repeat_period_ticks, item.confirm_ok));
                requests_taken <= requests_taken + 1;
            end

            fail_count <= fail_count + errs;
        end
    end

endmodule

// File: bench/tb_pdu_tx_mode_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_pdu_tx_mode_scheduler_core
// Drives directed and random scheduler requests under several PDU counts,
// with random gaps and stalls on both channels and two long receiver holds,
// and reports the verdict from the failure count of the checker.
// ----------------------------------------------------------------------------
module tb_pdu_tx_mode_scheduler_core;
    import pts_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned SLOTS       = PDU_SLOTS_DEF;

    typedef struct packed {
        op_t         op;
        logic [5:0]  idx;
        logic        active;
        mode_t       mode;
        logic [15:0] period;
        logic [7:0]  reps;
        logic [15:0] rep_period;
        logic        ok;
    } req_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [6:0]  cfg_wr_data;
    logic        no_idle;
    int unsigned fail_count;
    int unsigned requests_taken;
    int unsigned results_taken;
    int unsigned quiet_cycles = 0;

    // per-PDU settings used by well-formed random requests
    mode_t       prof_mode       [SLOTS];
    logic [15:0] prof_period     [SLOTS];
    logic [7:0]  prof_reps       [SLOTS];
    logic [15:0] prof_rep_period [SLOTS];

    pts_in_if  item_ch ();
    pts_out_if result_ch ();

    pdu_tx_mode_scheduler_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item_ch),
        .result      (result_ch)
    );

    pts_sched_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .item           (item_ch),
        .result         (result_ch),
        .fail_count     (fail_count),
        .requests_taken (requests_taken),
        .results_taken  (results_taken)
    );

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic req_t make_req(
        input op_t         op,
        input logic [5:0]  idx,
        input logic        active,
        input mode_t       mode,
        input logic [15:0] period,
        input logic [7:0]  reps,
        input logic [15:0] rep_period,
        input logic        ok
    );
        req_t r;
        r = '{op, idx, active, mode, period, reps, rep_period, ok};
        return r;
    endfunction

    // one request transfer after a random gap
    task automatic send_request(input req_t r);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid               <= 1'b1;
        item_ch.operation           <= r.op;
        item_ch.pdu_index           <= r.idx;
        item_ch.pdu_active          <= r.active;
        item_ch.tx_mode             <= r.mode;
        item_ch.period_ticks        <= r.period;
        item_ch.repeat_total        <= r.reps;
        item_ch.repeat_period_ticks <= r.rep_period;
        item_ch.confirm_ok          <= r.ok;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (requests_taken != results_taken);
    endtask

    task automatic set_pdu_count(input logic [6:0] count);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= count;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly well-formed traffic on a hot set of PDUs, some noise
    task automatic random_phase(input logic [6:0] count, input int unsigned hot_top,
                                input int unsigned n_items, input logic calm);
        req_t        r;
        int unsigned pick;
        set_pdu_count(count);
        no_idle <= calm;
        for (int p = 0; p < SLOTS; p++)
        begin
            prof_mode[p]       = mode_t'(2'($urandom_range(0, 3)));
            prof_period[p]     = 16'($urandom_range(0, 6));
            prof_reps[p]       = 8'($urandom_range(0, 4));
            prof_rep_period[p] = 16'($urandom_range(0, 3));
        end
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                r.op         = op_t'(2'($urandom_range(0, 3)));
                r.idx        = 6'($urandom_range(0, 63));
                r.active     = 1'($urandom_range(0, 1));
                r.mode       = mode_t'(2'($urandom_range(0, 3)));
                r.period     = 16'($urandom);
                r.reps       = 8'($urandom);
                r.rep_period = 16'($urandom);
                r.ok         = 1'($urandom_range(0, 1));
            end
            else
            begin
                if (pick < 58)
                    r.op = OP_EVAL;
                else if (pick < 78)
                    r.op = OP_TRIG;
                else if (pick < 95)
                    r.op = OP_CONF;
                else
                    r.op = OP_RSVD;
                r.idx = ($urandom_range(0, 9) < 8) ? 6'($urandom_range(0, hot_top))
                                                   : 6'($urandom_range(0, 63));
                r.active     = ($urandom_range(0, 19) != 0);
                r.mode       = prof_mode[r.idx];
                r.period     = prof_period[r.idx];
                r.reps       = prof_reps[r.idx];
                r.rep_period = prof_rep_period[r.idx];
                r.ok         = ($urandom_range(0, 3) != 0);
            end
            send_request(r);
        end
    endtask

    // receiver: random stall per result, two long holds to back the block up
    initial
    begin
        int unsigned stall;
        int unsigned n;
        n = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            if (n == 150 || n == 420)
                stall = 300;
            else
                stall = no_idle ? 0 : $urandom_range(0, 16);
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            n++;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n                       <= 1'b0;
        cfg_wr_en                   <= 1'b0;
        cfg_wr_data                 <= '0;
        no_idle                     <= 1'b0;
        item_ch.valid               <= 1'b0;
        item_ch.operation           <= OP_EVAL;
        item_ch.pdu_index           <= '0;
        item_ch.pdu_active          <= 1'b0;
        item_ch.tx_mode             <= MODE_NONE;
        item_ch.period_ticks        <= '0;
        item_ch.repeat_total        <= '0;
        item_ch.repeat_period_ticks <= '0;
        item_ch.confirm_ok          <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // periodic: zero timer sends and reloads with the largest period
        send_request(make_req(OP_EVAL, 6'd0, 1'b1, MODE_PERIODIC, 16'hFFFF, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd0, 1'b1, MODE_PERIODIC, 16'hFFFF, 8'd0, 16'd0, 1'b0));
        // trigger ignores pdu_active; direct mode consumes the flag once
        send_request(make_req(OP_TRIG, 6'd63, 1'b0, MODE_MIXED, 16'hFFFF, 8'hFF, 16'hFFFF,
                              1'b1));
        send_request(make_req(OP_EVAL, 6'd63, 1'b1, MODE_DIRECT, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd63, 1'b1, MODE_DIRECT, 16'd0, 8'd0, 16'd0, 1'b0));
        // mixed: trigger starts repetitions, then period and repetition sends
        send_request(make_req(OP_TRIG, 6'd5, 1'b1, MODE_NONE, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        // failed confirmation keeps repetitions, a good one clears them
        send_request(make_req(OP_CONF, 6'd5, 1'b1, MODE_MIXED, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        send_request(make_req(OP_CONF, 6'd5, 1'b1, MODE_MIXED, 16'd0, 8'd0, 16'd0, 1'b1));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd5, 1'b1, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        // inactive PDU, mode none and the reserved operation leave the row alone
        send_request(make_req(OP_EVAL, 6'd5, 1'b0, MODE_MIXED, 16'd2, 8'hFF, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd6, 1'b1, MODE_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1));
        send_request(make_req(OP_RSVD, 6'd10, 1'b1, MODE_MIXED, 16'hFFFF, 8'hFF, 16'hFFFF,
                              1'b1));
        // mixed with no repetitions and largest repetition period
        send_request(make_req(OP_TRIG, 6'd7, 1'b1, MODE_MIXED, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_EVAL, 6'd7, 1'b1, MODE_MIXED, 16'hFFFF, 8'd0, 16'hFFFF, 1'b0));
        send_request(make_req(OP_EVAL, 6'd7, 1'b1, MODE_MIXED, 16'hFFFF, 8'd0, 16'hFFFF, 1'b0));
        send_request(make_req(OP_EVAL, 6'd7, 1'b1, MODE_MIXED, 16'hFFFF, 8'd0, 16'hFFFF, 1'b0));

        // no PDUs configured: every index rejected, trigger must not stick
        set_pdu_count(7'd0);
        send_request(make_req(OP_EVAL, 6'd0, 1'b1, MODE_PERIODIC, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_TRIG, 6'd63, 1'b1, MODE_DIRECT, 16'd0, 8'd0, 16'd0, 1'b0));

        // count above the table size: index limited by the slots only
        set_pdu_count(7'd127);
        send_request(make_req(OP_EVAL, 6'd63, 1'b1, MODE_DIRECT, 16'd0, 8'd0, 16'd0, 1'b0));
        send_request(make_req(OP_RSVD, 6'd63, 1'b0, MODE_NONE, 16'd0, 8'd0, 16'd0, 1'b0));

        random_phase(7'd64, 7, 120, 1'b0);
        random_phase(7'd1, 1, 50, 1'b0);
        random_phase(7'd127, 7, 120, 1'b1);
        random_phase(7'd32, 35, 80, 1'b0);
        random_phase(7'd0, 3, 20, 1'b0);
        random_phase(7'($urandom_range(0, 127)), 9, 140, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && requests_taken == results_taken)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
